>>> sv/lossless_jpeg_left_predict_sliced_macros.svh
// ----------------------------------------------------------------------------
// lossless_jpeg_left_predict_sliced_macros.svh
// assertion helpers shared by the predictor rtl
// ----------------------------------------------------------------------------
`ifndef LOSSLESS_JPEG_LEFT_PREDICT_SLICED_MACROS_SVH
`define LOSSLESS_JPEG_LEFT_PREDICT_SLICED_MACROS_SVH

// same-cycle implication, checked out of reset
`define LJLP_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define LJLP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

>>> sv/ljlp_pkg.sv
// ----------------------------------------------------------------------------
// ljlp_pkg
// constants, register map and types for the lossless jpeg left predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ljlp_pkg;

  localparam int MAX_COMPONENTS_DEF = 4;
  localparam int MAX_SLICES_DEF     = 15;
  localparam int COORD_BITS_DEF     = 16;

  localparam int DIFF_W      = 17;
  localparam int SAMPLE_W    = 16;
  localparam int COMP_W      = 2;
  localparam int POS_W       = 16;
  localparam int SLICE_W     = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_COMPONENT_COUNT   = 3'd0,
    REG_START_SHIFT       = 3'd1,
    REG_ROW_PIXELS        = 3'd2,
    REG_SKIPPED_PIXELS    = 3'd3,
    REG_ROW_COUNT         = 3'd4,
    REG_SLICE_COUNT       = 3'd5,
    REG_SLICE_WIDTH       = 3'd6,
    REG_FINAL_SLICE_WIDTH = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                   last;
    logic [OUT_TDATA_W-1:0] data;
  } result_t;

endpackage

`default_nettype wire

>>> sv/lossless_jpeg_left_predict_sliced.sv
// ----------------------------------------------------------------------------
// lossless_jpeg_left_predict_sliced
// left-predictor reconstruction of interleaved lossless jpeg samples with
// vertical slice remap of the destination coordinates
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | tvalid/tready       | tdata: difference, tuser: scan_start
//  out_    | out | tvalid/tready       | tdata: sample, comp, column, row;
//          |     |                     | tlast: scan_done
//  cfg_    | in  | apb psel/penable    | 8 registers at byte address 4*i
//
//  one request per cycle while in_tready is high; a result is registered in
//  the output register, or in the skid while out stalls
//  the predictor add and the next values of all position counters are combinational
//  a two-entry output (register plus skid) keeps input open while out stalls
//  in_tready drops only when both output entries are full
//  rst_n is synchronous; no clearing pass, usable right after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lossless_jpeg_left_predict_sliced_macros.svh"

module lossless_jpeg_left_predict_sliced
  import ljlp_pkg::*;
#(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF,
  parameter int MAX_SLICES     = MAX_SLICES_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // stream in
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [IN_TDATA_W-1:0]  in_tdata,   // [16:0] difference, only [15:0] used; rest zero
  input  wire  [0:0]             in_tuser,   // [0] scan_start
  // stream out
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] sample_value, [17:16]
                                             // component_index, [33:18]
                                             // dest_column, [49:34] dest_row
  output logic                   out_tlast,  // scan_done
  // configuration
  input  wire                    cfg_psel,
  input  wire                    cfg_penable,
  input  wire                    cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire  [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CI_W = $clog2(MAX_COMPONENTS);
  localparam logic [2:0]         MAX_COMP_C  = 3'(MAX_COMPONENTS);
  localparam logic [SLICE_W-1:0] MAX_SLICE_C = SLICE_W'(MAX_SLICES);

  // configuration registers
  logic [2:0]         cc_r;
  logic [4:0]         sh_r;
  logic [POS_W-1:0]   rp_r, skip_r, rows_r, sw_r, fsw_r;
  logic [SLICE_W-1:0] sc_r;

  // scan state
  logic [SAMPLE_W-1:0]   pred_r [MAX_COMPONENTS];
  logic [SAMPLE_W-1:0]   rfv_r  [MAX_COMPONENTS];
  logic [COMP_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]      col_r, col_nxt, row_r, row_nxt;
  logic [SLICE_W-1:0]    snum_r, snum_nxt;
  logic [POS_W-1:0]      left_r, left_nxt, srow_r, srow_nxt;
  logic [COORD_BITS-1:0] xbase_r, xbase_nxt;
  logic                  active_r, active_nxt;

  // output register and skid
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;

  cfg_reg_t cfg_sel;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_sel)
      REG_COMPONENT_COUNT:   cfg_prdata = 32'(cc_r);
      REG_START_SHIFT:       cfg_prdata = 32'(sh_r);
      REG_ROW_PIXELS:        cfg_prdata = 32'(rp_r);
      REG_SKIPPED_PIXELS:    cfg_prdata = 32'(skip_r);
      REG_ROW_COUNT:         cfg_prdata = 32'(rows_r);
      REG_SLICE_COUNT:       cfg_prdata = 32'(sc_r);
      REG_SLICE_WIDTH:       cfg_prdata = 32'(sw_r);
      REG_FINAL_SLICE_WIDTH: cfg_prdata = 32'(fsw_r);
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r   <= 3'd2;
      sh_r   <= 5'd16;
      rp_r   <= 16'd1;
      skip_r <= '0;
      rows_r <= 16'd1;
      sc_r   <= 4'd1;
      sw_r   <= 16'd1;
      fsw_r  <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_COMPONENT_COUNT:   cc_r   <= cfg_pwdata[2:0];
        REG_START_SHIFT:       sh_r   <= cfg_pwdata[4:0];
        REG_ROW_PIXELS:        rp_r   <= cfg_pwdata[15:0];
        REG_SKIPPED_PIXELS:    skip_r <= cfg_pwdata[15:0];
        REG_ROW_COUNT:         rows_r <= cfg_pwdata[15:0];
        REG_SLICE_COUNT:       sc_r   <= cfg_pwdata[3:0];
        REG_SLICE_WIDTH:       sw_r   <= cfg_pwdata[15:0];
        REG_FINAL_SLICE_WIDTH: fsw_r  <= cfg_pwdata[15:0];
        default:               ;
      endcase
    end
  end

  // clamped register views
  logic [2:0]          comps;
  logic [SLICE_W-1:0]  slices;
  logic [POS_W-1:0]    rp, rows, swe, fswe, kept;
  logic [4:0]          shc;
  logic [SAMPLE_W-1:0] first_base;

  always_comb begin
    if (cc_r < 3'd2)            comps = 3'd2;
    else if (cc_r > MAX_COMP_C) comps = MAX_COMP_C;
    else                        comps = cc_r;
    if (sc_r == '0)              slices = SLICE_W'(1);
    else if (sc_r > MAX_SLICE_C) slices = MAX_SLICE_C;
    else                         slices = sc_r;
    rp   = (rp_r   == '0) ? 16'd1 : rp_r;
    rows = (rows_r == '0) ? 16'd1 : rows_r;
    swe  = (sw_r   == '0) ? 16'd1 : sw_r;
    fswe = (fsw_r  == '0) ? 16'd1 : fsw_r;
    kept = (skip_r < rp) ? rp - skip_r : '0;
    if (sh_r == '0)        shc = 5'd1;
    else if (sh_r > 5'd16) shc = 5'd16;
    else                   shc = sh_r;
    first_base = 16'd1 << (shc - 5'd1);
  end

  // effective state once a scan_start has been applied
  logic                  in_fire, start, e_active;
  logic [COMP_W-1:0]     e_pos, c;
  logic [POS_W-1:0]      e_col, e_row, e_srow, e_left, left1, w_cur;
  logic [SLICE_W-1:0]    e_snum;
  logic [COORD_BITS-1:0] e_xbase;
  logic [CI_W-1:0]       ci;
  logic                  last_comp, emit, done;
  logic [SAMPLE_W-1:0]   base, val;
  logic [POS_W-1:0]      dcol_full;
  logic [15:0]           dest_col, dest_row;
  logic [POS_W:0]        col_inc, row_inc;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign start     = in_tuser[0];

  always_comb begin
    e_active = start | active_r;
    e_pos    = start ? '0 : pos_r;
    e_col    = start ? '0 : col_r;
    e_row    = start ? '0 : row_r;
    e_snum   = start ? '0 : snum_r;
    e_srow   = start ? '0 : srow_r;
    e_xbase  = start ? '0 : xbase_r;
    e_left   = start ? ((slices <= SLICE_W'(1)) ? fswe : swe) : left_r;

    c         = ({1'b0, e_pos} >= comps) ? COMP_W'(comps - 3'd1) : e_pos;
    ci        = c[CI_W-1:0];
    last_comp = ({1'b0, c} + 3'd1 >= comps);
    emit      = e_active & (e_col < kept);

    if (e_col != '0)      base = pred_r[ci];
    else if (e_row != '0) base = rfv_r[ci];
    else                  base = first_base;
    val = base + in_tdata[SAMPLE_W-1:0];

    done = last_comp && ({1'b0, e_row} + 17'd1 >= {1'b0, rows})
           && ({1'b0, e_col} + 17'd1 == {1'b0, kept});

    w_cur     = ({1'b0, e_snum} + 5'd1 >= {1'b0, slices}) ? fswe : swe;
    dcol_full = 16'(e_xbase) + w_cur - e_left;
    dest_col  = 16'(dcol_full[COORD_BITS-1:0]);
    dest_row  = 16'(e_srow[COORD_BITS-1:0]);

    // slice walk: column within slice, then row, then next slice
    left1     = (e_left == '0) ? '0 : e_left - 16'd1;
    left_nxt  = e_left;
    srow_nxt  = e_srow;
    snum_nxt  = e_snum;
    xbase_nxt = e_xbase;
    if (emit && last_comp) begin
      if (left1 != '0) begin
        left_nxt = left1;
      end else begin
        if ({1'b0, e_srow} + 17'd1 < {1'b0, rows}) begin
          srow_nxt = e_srow + 16'd1;
        end else if ({1'b0, e_snum} + 5'd1 < {1'b0, slices}) begin
          srow_nxt  = '0;
          xbase_nxt = e_xbase + swe[COORD_BITS-1:0];
          snum_nxt  = e_snum + SLICE_W'(1);
        end else begin
          srow_nxt = rows - 16'd1;
        end
        left_nxt = ({1'b0, snum_nxt} + 5'd1 >= {1'b0, slices}) ? fswe : swe;
      end
    end

    col_inc    = {1'b0, e_col} + 17'd1;
    row_inc    = {1'b0, e_row} + 17'd1;
    pos_nxt    = e_pos;
    col_nxt    = e_col;
    row_nxt    = e_row;
    active_nxt = e_active;
    if (last_comp) begin
      pos_nxt = '0;
      if (col_inc >= {1'b0, rp}) begin
        col_nxt = '0;
        if (row_inc >= {1'b0, rows}) begin
          row_nxt    = '0;
          active_nxt = 1'b0;
        end else begin
          row_nxt = row_inc[POS_W-1:0];
        end
      end else begin
        col_nxt = col_inc[POS_W-1:0];
      end
    end else begin
      pos_nxt = c + COMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        pred_r[i] <= '0;
        rfv_r[i]  <= '0;
      end
      pos_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      snum_r   <= '0;
      left_r   <= '0;
      srow_r   <= '0;
      xbase_r  <= '0;
      active_r <= 1'b0;
    end else if (in_fire && e_active) begin
      // a scan start clears every component except the one written now
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        if (emit && (ci == CI_W'(i))) begin
          pred_r[i] <= val;
          if (e_col == '0) rfv_r[i] <= val;
        end else if (start) begin
          pred_r[i] <= '0;
          rfv_r[i]  <= '0;
        end
      end
      pos_r    <= pos_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      snum_r   <= snum_nxt;
      left_r   <= left_nxt;
      srow_r   <= srow_nxt;
      xbase_r  <= xbase_nxt;
      active_r <= active_nxt;
    end
  end

  // result staging
  result_t res_nxt;
  logic    res_new, out_free;

  assign res_nxt.last = done;
  assign res_nxt.data = {6'd0, dest_row, dest_col, c, val};
  assign res_new      = in_fire & emit;
  assign out_free     = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_new;
      end
    end else if (res_new) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (res_new) out_r <= res_nxt;
    end else if (res_new) begin
      skid_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tlast  = out_r.last;

  `LJLP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `LJLP_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
                    out_valid_r && !out_tready && res_new, skid_valid_r)
  `LJLP_ASSERT_SAME(a_idle_at_origin, clk, rst_n, !active_r,
                    col_r == '0 && row_r == '0 && pos_r == '0)
  `LJLP_ASSERT_SAME(a_slice_count_live, clk, rst_n, active_r, left_r != '0)

endmodule

`default_nettype wire
